// File: rtl/wpp_pkg.sv
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types and constants for the WAV PCM16 stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wpp_pkg;

  typedef enum logic [2:0] {
    PH_FILEHDR,
    PH_CKHDR,
    PH_BODY,
    PH_PAD,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_FMT,
    KIND_DATA
  } chunk_kind_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SMALL     = 4'd1,
    ST_MAGIC     = 4'd2,
    ST_FMT_SHORT = 4'd3,
    ST_NOT_PCM   = 4'd4,
    ST_CHANNELS  = 4'd5,
    ST_BITS      = 4'd6,
    ST_NO_DATA   = 4'd7,
    ST_ODD       = 4'd8
  } status_e;

  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam logic [3:0]  MAGIC_LEN     = 4'd4;
  localparam logic [3:0]  FILE_HDR_LEN  = 4'd12;
  localparam logic [3:0]  CHUNK_ID_LEN  = 4'd4;
  localparam logic [3:0]  CHUNK_HDR_LEN = 4'd8;
  localparam logic [31:0] FMT_MIN_LEN   = 32'd16;
  localparam logic [7:0]  FMT_PCM_CODE  = 8'd1;
  localparam logic [7:0]  FMT_BITS_16   = 8'd16;
  localparam logic [15:0] TAG_MAX       = 16'hFFFF;

  // fmt body offsets of interest
  localparam logic [3:0] OFF_FMT_LO  = 4'd0;
  localparam logic [3:0] OFF_FMT_HI  = 4'd1;
  localparam logic [3:0] OFF_CH_LO   = 4'd2;
  localparam logic [3:0] OFF_CH_HI   = 4'd3;
  localparam logic [3:0] OFF_RATE_0  = 4'd4;
  localparam logic [3:0] OFF_RATE_1  = 4'd5;
  localparam logic [3:0] OFF_RATE_2  = 4'd6;
  localparam logic [3:0] OFF_RATE_3  = 4'd7;
  localparam logic [3:0] OFF_BITS_LO = 4'd14;
  localparam logic [3:0] OFF_BITS_HI = 4'd15;

  typedef struct packed {
    logic [31:0] rate;
    logic [15:0] channels;
    logic        pcm;
    logic        b16;
  } fmt_t;

  typedef struct packed {
    logic        valid;
    logic        empty;
    logic        odd;
    logic [15:0] tag;
  } chosen_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] pcm_sample;
    logic [15:0] sample_chunk_tag;
    logic [3:0]  parse_status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] chosen_chunk_tag;
    logic        last_result;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/wpp_byte_if.sv
// ----------------------------------------------------------------------------
// wpp_byte_if
// Byte stream channel: one file byte and an end-of-file flag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// File: rtl/wpp_result_if.sv
// ----------------------------------------------------------------------------
// wpp_result_if
// Result channel: a sample or an end-of-file summary per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpp_result_if;
  logic               valid;
  logic               ready;
  logic               item_kind;
  logic signed [15:0] pcm_sample;
  logic        [15:0] sample_chunk_tag;
  logic        [3:0]  parse_status;
  logic        [31:0] sample_rate;
  logic        [15:0] channel_count;
  logic        [15:0] chosen_chunk_tag;
  logic               last_result;

  modport source (output valid, output item_kind, output pcm_sample,
                  output sample_chunk_tag, output parse_status, output sample_rate,
                  output channel_count, output chosen_chunk_tag, output last_result,
                  input ready);
  modport sink   (input valid, input item_kind, input pcm_sample,
                  input sample_chunk_tag, input parse_status, input sample_rate,
                  input channel_count, input chosen_chunk_tag, input last_result,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/wav_pcm16_stream_parser.sv
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser
// Streams a WAV file byte by byte, emits PCM16 samples per data chunk and
// one status summary on the final byte.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  byte_i   in   file_byte, end_of_file
//  res_o    out  item_kind, pcm_sample, sample_chunk_tag, parse_status,
//                sample_rate, channel_count, chosen_chunk_tag, last_result
//
//  One byte per cycle while byte_i.ready is high; a result appears in the cycle after its byte's transfer.
//  The per-byte update is one pass through the parse state registers.
//  Reset clears all parse state; the end-of-file byte also returns it to reset.
//  byte_i.ready drops only while a held result waits on res_o.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm16_stream_parser (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  wpp_byte_if.sink     byte_i,
  wpp_result_if.source res_o
);

  logic             fire;
  logic             load_ready;
  logic             res_valid;
  wpp_pkg::result_t res;

  assign byte_i.ready = load_ready;
  assign fire         = byte_i.valid && load_ready;

  wpp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .file_byte_i   (byte_i.file_byte),
    .end_of_file_i (byte_i.end_of_file),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  wpp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .load_ready_o (load_ready),
    .res_o        (res_o)
  );

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !byte_i.ready)
    else $error("byte taken while result register is stalled");

  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.last_result == res_o.item_kind)
    else $error("last_result disagrees with item_kind");

  a_sample_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.item_kind |-> res_o.sample_chunk_tag != 16'd0)
    else $error("sample transfer with zero chunk tag");

endmodule

`default_nettype wire

// File: rtl/wpp_parser.sv
// ----------------------------------------------------------------------------
// wpp_parser
// Parse state registers and the per-byte update: header magic, chunk walk,
// fmt capture and commit, sample assembly and the end-of-file summary.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [7:0]      file_byte_i,
  input  wire logic            end_of_file_i,
  output      logic            res_valid_o,
  output      wpp_pkg::result_t res_o
);

  wpp_pkg::phase_e      phase_q, phase_d;
  logic [3:0]           pos_q, pos_d;
  logic [31:0]          id_q, id_d;
  logic [31:0]          size_q, size_d;
  logic [31:0]          left_q, left_d;
  logic [4:0]           off_q, off_d;
  wpp_pkg::chunk_kind_e kind_q, kind_d;
  wpp_pkg::fmt_t        shadow_q, shadow_d;
  wpp_pkg::fmt_t        commit_q, commit_d;
  logic                 hold_vld_q, hold_vld_d;
  logic [7:0]           hold_byte_q, hold_byte_d;
  logic [15:0]          count_q, count_d;
  wpp_pkg::chosen_t     chosen_q, chosen_d;
  wpp_pkg::status_e     err_q, err_d;

  logic                 start_chunk;
  logic                 finish_chunk;
  logic                 have_smp;
  logic [15:0]          smp;
  logic [15:0]          tag;
  wpp_pkg::status_e     status;

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    id_d         = id_q;
    size_d       = size_q;
    left_d       = left_q;
    off_d        = off_q;
    kind_d       = kind_q;
    shadow_d     = shadow_q;
    commit_d     = commit_q;
    hold_vld_d   = hold_vld_q;
    hold_byte_d  = hold_byte_q;
    count_d      = count_q;
    chosen_d     = chosen_q;
    err_d        = err_q;
    start_chunk  = 1'b0;
    finish_chunk = 1'b0;
    have_smp     = 1'b0;
    smp          = '0;
    tag          = '0;
    status       = wpp_pkg::ST_OK;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (fire_i) begin
      case (phase_q)
        wpp_pkg::PH_FILEHDR: begin
          id_d  = {id_q[23:0], file_byte_i};
          pos_d = pos_q + 4'd1;
          if (pos_d == wpp_pkg::MAGIC_LEN && id_d != wpp_pkg::ID_RIFF) begin
            err_d = wpp_pkg::ST_MAGIC;
          end
          if (pos_d >= wpp_pkg::FILE_HDR_LEN) begin
            if (id_d != wpp_pkg::ID_WAVE) begin
              err_d = wpp_pkg::ST_MAGIC;
            end
            pos_d   = '0;
            phase_d = (err_d != wpp_pkg::ST_OK) ? wpp_pkg::PH_HALT : wpp_pkg::PH_CKHDR;
          end
        end
        wpp_pkg::PH_CKHDR: begin
          if (pos_q < wpp_pkg::CHUNK_ID_LEN) begin
            id_d = {id_q[23:0], file_byte_i};
          end else begin
            size_d = {file_byte_i, size_q[31:8]};
          end
          pos_d = pos_q + 4'd1;
          if (pos_d >= wpp_pkg::CHUNK_HDR_LEN) begin
            pos_d       = '0;
            start_chunk = 1'b1;
          end
        end
        wpp_pkg::PH_BODY: begin
          if (kind_q == wpp_pkg::KIND_FMT && !off_q[4]) begin
            case (off_q[3:0])
              wpp_pkg::OFF_FMT_LO:  shadow_d.pcm = (file_byte_i == wpp_pkg::FMT_PCM_CODE);
              wpp_pkg::OFF_FMT_HI:  if (file_byte_i != 8'd0) shadow_d.pcm = 1'b0;
              wpp_pkg::OFF_CH_LO:   shadow_d.channels[7:0]  = file_byte_i;
              wpp_pkg::OFF_CH_HI:   shadow_d.channels[15:8] = file_byte_i;
              wpp_pkg::OFF_RATE_0:  shadow_d.rate[7:0]      = file_byte_i;
              wpp_pkg::OFF_RATE_1:  shadow_d.rate[15:8]     = file_byte_i;
              wpp_pkg::OFF_RATE_2:  shadow_d.rate[23:16]    = file_byte_i;
              wpp_pkg::OFF_RATE_3:  shadow_d.rate[31:24]    = file_byte_i;
              wpp_pkg::OFF_BITS_LO: shadow_d.b16 = (file_byte_i == wpp_pkg::FMT_BITS_16);
              wpp_pkg::OFF_BITS_HI: if (file_byte_i != 8'd0) shadow_d.b16 = 1'b0;
              default: ;
            endcase
          end else if (kind_q == wpp_pkg::KIND_DATA) begin
            if (hold_vld_q) begin
              smp         = {file_byte_i, hold_byte_q};
              tag         = count_q;
              have_smp    = 1'b1;
              hold_vld_d  = 1'b0;
              hold_byte_d = '0;
            end else begin
              hold_vld_d  = 1'b1;
              hold_byte_d = file_byte_i;
            end
          end
          off_d  = off_q[4] ? off_q : off_q + 5'd1;
          left_d = left_q - 32'd1;
          if (left_d == '0) begin
            finish_chunk = 1'b1;
          end
        end
        wpp_pkg::PH_PAD: phase_d = wpp_pkg::PH_CKHDR;
        default: ;
      endcase

      if (start_chunk) begin
        if (id_d == wpp_pkg::ID_FMT) begin
          kind_d   = wpp_pkg::KIND_FMT;
          shadow_d = '0;
        end else if (id_d == wpp_pkg::ID_DATA) begin
          kind_d      = wpp_pkg::KIND_DATA;
          count_d     = (count_q == wpp_pkg::TAG_MAX) ? count_q : count_q + 16'd1;
          hold_vld_d  = 1'b0;
          hold_byte_d = '0;
        end else begin
          kind_d = wpp_pkg::KIND_OTHER;
        end
        left_d = size_d;
        off_d  = '0;
        if (size_d == '0) begin
          finish_chunk = 1'b1;
        end else begin
          phase_d = wpp_pkg::PH_BODY;
        end
      end

      if (finish_chunk) begin
        if (kind_d == wpp_pkg::KIND_FMT && size_d < wpp_pkg::FMT_MIN_LEN) begin
          err_d   = wpp_pkg::ST_FMT_SHORT;
          phase_d = wpp_pkg::PH_HALT;
        end else begin
          if (kind_d == wpp_pkg::KIND_FMT) begin
            commit_d = shadow_d;
          end else if (kind_d == wpp_pkg::KIND_DATA) begin
            chosen_d.valid = 1'b1;
            chosen_d.tag   = count_d;
            chosen_d.empty = (size_d == '0);
            chosen_d.odd   = size_d[0];
          end
          phase_d = size_d[0] ? wpp_pkg::PH_PAD : wpp_pkg::PH_CKHDR;
        end
      end

      if (phase_d == wpp_pkg::PH_FILEHDR) begin
        status = wpp_pkg::ST_SMALL;
      end else if (err_d != wpp_pkg::ST_OK) begin
        status = err_d;
      end else if (!commit_d.pcm) begin
        status = wpp_pkg::ST_NOT_PCM;
      end else if (commit_d.channels != 16'd1 && commit_d.channels != 16'd2) begin
        status = wpp_pkg::ST_CHANNELS;
      end else if (!commit_d.b16) begin
        status = wpp_pkg::ST_BITS;
      end else if (!chosen_d.valid || chosen_d.empty) begin
        status = wpp_pkg::ST_NO_DATA;
      end else if (chosen_d.odd) begin
        status = wpp_pkg::ST_ODD;
      end

      res_o.pcm_sample       = smp;
      res_o.sample_chunk_tag = tag;
      if (end_of_file_i) begin
        res_valid_o            = 1'b1;
        res_o.item_kind        = 1'b1;
        res_o.parse_status     = status;
        res_o.sample_rate      = commit_d.rate;
        res_o.channel_count    = commit_d.channels;
        res_o.chosen_chunk_tag = chosen_d.valid ? chosen_d.tag : '0;
        res_o.last_result      = 1'b1;

        phase_d     = wpp_pkg::PH_FILEHDR;
        pos_d       = '0;
        id_d        = '0;
        size_d      = '0;
        left_d      = '0;
        off_d       = '0;
        kind_d      = wpp_pkg::KIND_OTHER;
        shadow_d    = '0;
        commit_d    = '0;
        hold_vld_d  = 1'b0;
        hold_byte_d = '0;
        count_d     = '0;
        chosen_d    = '0;
        err_d       = wpp_pkg::ST_OK;
      end else begin
        res_valid_o = have_smp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wpp_pkg::PH_FILEHDR;
      pos_q       <= '0;
      id_q        <= '0;
      size_q      <= '0;
      left_q      <= '0;
      off_q       <= '0;
      kind_q      <= wpp_pkg::KIND_OTHER;
      shadow_q    <= '0;
      commit_q    <= '0;
      hold_vld_q  <= 1'b0;
      hold_byte_q <= '0;
      count_q     <= '0;
      chosen_q    <= '0;
      err_q       <= wpp_pkg::ST_OK;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      id_q        <= id_d;
      size_q      <= size_d;
      left_q      <= left_d;
      off_q       <= off_d;
      kind_q      <= kind_d;
      shadow_q    <= shadow_d;
      commit_q    <= commit_d;
      hold_vld_q  <= hold_vld_d;
      hold_byte_q <= hold_byte_d;
      count_q     <= count_d;
      chosen_q    <= chosen_d;
      err_q       <= err_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wpp_out_reg.sv
// ----------------------------------------------------------------------------
// wpp_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_valid_i,
  input  wire wpp_pkg::result_t res_i,
  output      logic             load_ready_o,
  wpp_result_if.source          res_o
);

  logic             valid_q;
  wpp_pkg::result_t data_q;

  assign load_ready_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid            = valid_q;
  assign res_o.item_kind        = data_q.item_kind;
  assign res_o.pcm_sample       = $signed(data_q.pcm_sample);
  assign res_o.sample_chunk_tag = data_q.sample_chunk_tag;
  assign res_o.parse_status     = data_q.parse_status;
  assign res_o.sample_rate      = data_q.sample_rate;
  assign res_o.channel_count    = data_q.channel_count;
  assign res_o.chosen_chunk_tag = data_q.chosen_chunk_tag;
  assign res_o.last_result      = data_q.last_result;

endmodule

`default_nettype wire
